FILE: rtl/assert_macros.svh
// assertion macros shared by the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a check that holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a check that holds at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/cmrc_pkg.sv
// package: types, constants and hash helpers for the count-min reference counter
package cmrc_pkg;

    localparam int ROW_WIDTH_DEF     = 4096;
    localparam int ROWS_DEF          = 4;
    localparam int OVERFLOW_BITS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 17;
    localparam int NIBBLE_W = 4;

    localparam logic [NIBBLE_W-1:0] NIBBLE_MAX = 4'd15;
    localparam logic [31:0] SEED_STEP = 32'd1003;
    localparam logic [31:0] SEED_BASE = 32'd7;

    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_REF   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEREF = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_MOD0,
        ST_MOD1,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // multiplier operand selection for the shared unit
    typedef enum logic [2:0] {
        MS_SEED,
        MS_LO,
        MS_ROT,
        MS_HI,
        MS_AV2,
        MS_AV3,
        MS_RECIP,
        MS_QW
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
    } hash_ctl_t;

    function automatic logic [31:0] rotl17(input logic [31:0] x);
        rotl17 = {x[14:0], x[31:15]};
    endfunction

endpackage

FILE: rtl/cmrc_hash_unit.sv
// shared 32x32 multiplier datapath computing the xxh32 of one 8-byte key and its bucket column
module cmrc_hash_unit #(
    parameter int ROW_WIDTH = cmrc_pkg::ROW_WIDTH_DEF
) (
    input  logic                       aclk,
    input  cmrc_pkg::hash_ctl_t        ctl,
    input  logic [31:0]                row_idx,
    input  logic [cmrc_pkg::KEY_W-1:0] key,
    output logic [31:0]                col
);
    localparam int COL_W = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam logic [31:0] ROW_WIDTH_C = 32'(ROW_WIDTH);
    // floor(2^32 / width): the quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'(64'd4294967296 / 64'(ROW_WIDTH));

    logic [31:0] acc_reg, acc_next;
    logic [31:0] a, b;
    logic [31:0] av;
    logic [31:0] hash;

    assign av   = acc_reg;
    assign hash = av ^ (av >> 16);

    always_comb begin
        a = '0;
        b = '0;
        case (ctl.mul_sel)
            cmrc_pkg::MS_SEED:  begin a = row_idx; b = cmrc_pkg::SEED_STEP; end
            cmrc_pkg::MS_LO:    begin a = key[31:0]; b = cmrc_pkg::PR3; end
            cmrc_pkg::MS_ROT:   begin a = cmrc_pkg::rotl17(av); b = cmrc_pkg::PR4; end
            cmrc_pkg::MS_HI:    begin a = key[63:32]; b = cmrc_pkg::PR3; end
            cmrc_pkg::MS_AV2:   begin a = av ^ (av >> 15); b = cmrc_pkg::PR2; end
            cmrc_pkg::MS_AV3:   begin a = av ^ (av >> 13); b = cmrc_pkg::PR3; end
            cmrc_pkg::MS_RECIP: begin a = hash; b = RECIP; end
            cmrc_pkg::MS_QW:    begin a = av; b = ROW_WIDTH_C; end
            default:            begin a = '0; b = '0; end
        endcase
    end

    // product low word, plus the running sum where xxh32 adds; the high word for the reciprocal step
    logic [63:0] prod;
    assign prod = {32'd0, a} * {32'd0, b};

    always_comb begin
        case (ctl.mul_sel)
            cmrc_pkg::MS_SEED:  acc_next = prod[31:0] + cmrc_pkg::SEED_BASE
                                           + cmrc_pkg::PR5 + 32'd8;
            cmrc_pkg::MS_LO,
            cmrc_pkg::MS_HI:    acc_next = av + prod[31:0];
            cmrc_pkg::MS_RECIP: acc_next = prod[63:32];
            default:            acc_next = prod[31:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            acc_reg <= acc_next;
        end
    end

    // bucket column: a mask for a power-of-two width, else the remainder
    // from the quotient estimate times the width, with one correction step
    generate
        if ((1 << COL_W) == ROW_WIDTH) begin : g_pow2
            assign col = hash & (ROW_WIDTH_C - 32'd1);
        end else begin : g_mod
            logic [31:0] h_keep_reg;
            logic [31:0] rem;
            always_ff @(posedge aclk) begin
                if (ctl.mul_en && (ctl.mul_sel == cmrc_pkg::MS_RECIP)) begin
                    h_keep_reg <= hash;
                end
            end
            assign rem = h_keep_reg - av;
            assign col = (rem >= ROW_WIDTH_C) ? (rem - ROW_WIDTH_C) : rem;
        end
    endgenerate
endmodule

FILE: rtl/cmrc_bucket_store.sv
// nibble and overflow counter memories with one read and one write port each
module cmrc_bucket_store #(
    parameter int ADDR_W = 14,
    parameter int OVF_W  = 16
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [cmrc_pkg::NIBBLE_W-1:0] wr_nib,
    input  logic [OVF_W-1:0]              wr_ovf,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [cmrc_pkg::NIBBLE_W-1:0] rd_nib,
    output logic [OVF_W-1:0]              rd_ovf
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [cmrc_pkg::NIBBLE_W-1:0] nib_mem [DEPTH];
    logic [OVF_W-1:0]              ovf_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            nib_mem[wr_addr] <= wr_nib;
            ovf_mem[wr_addr] <= wr_ovf;
        end
        rd_nib <= nib_mem[rd_addr];
        rd_ovf <= ovf_mem[rd_addr];
    end
endmodule

FILE: rtl/count_min_reference_counter_core.sv
// top level of the count-min reference counter
//
//  channel | dir | fields
//  s_axis  | in  | tdata: op[1:0], key[65:2], zero fill to 72 bits
//  m_axis  | out | tdata: count[16:0], zero fill to 24; tuser: underflow
//
// each beat runs, per row, one seed multiply and six hash multiplies
// through the one shared 32x32 multiplier, a memory read and, for ref
// and deref, a write-back; the done state then hands the result over,
// waiting while an earlier result is still undelivered, and the idle
// state takes the next beat; a row width that is not a power of two
// adds two multiplies per row for the column; after reset a clearing
// pass zeroes every bucket, and the input is not ready meanwhile
// a finished result sits in the output register while the next beat is
// worked on; only the following result waits for it to be delivered
module count_min_reference_counter_core #(
    parameter int ROW_WIDTH     = cmrc_pkg::ROW_WIDTH_DEF,
    parameter int ROWS          = cmrc_pkg::ROWS_DEF,
    parameter int OVERFLOW_BITS = cmrc_pkg::OVERFLOW_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // op[1:0], key[65:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // count[16:0]
    output logic        m_axis_tuser    // underflow
);
`include "assert_macros.svh"

    localparam int COL_W  = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = $clog2(ROWS * (1 << COL_W));
    localparam int CLR_W  = ADDR_W + 1;
    localparam int SUM_W  = OVERFLOW_BITS + 1;
    localparam bit COL_POW2 = ((1 << COL_W) == ROW_WIDTH);
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = '1;
    localparam logic [31:0] ROW_WIDTH_C = 32'(ROW_WIDTH);
    localparam logic [CLR_W-1:0] CLR_END = CLR_W'(ROWS * ROW_WIDTH);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    cmrc_pkg::state_t state_reg, state_next;

    logic [cmrc_pkg::OP_W-1:0]  op_reg;
    logic [cmrc_pkg::KEY_W-1:0] key_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [CLR_W-1:0]           clr_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [SUM_W-1:0]           best_reg;
    logic                       under_reg;
    logic [cmrc_pkg::COUNT_W-1:0] count_reg;
    logic                       out_under_reg;
    logic                       out_valid_reg;

    cmrc_pkg::hash_ctl_t hctl;
    logic [31:0] col;

    cmrc_hash_unit #(.ROW_WIDTH(ROW_WIDTH)) u_hash (
        .aclk    (aclk),
        .ctl     (hctl),
        .row_idx ({{(32-ROW_W){1'b0}}, row_reg}),
        .key     (key_reg),
        .col     (col)
    );

    // bucket address from the finished column, valid in the read cycle
    logic [ADDR_W-1:0] addr_next;
    assign addr_next = ADDR_W'({{(32-ROW_W){1'b0}}, row_reg} * ROW_WIDTH_C + col);

    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [cmrc_pkg::NIBBLE_W-1:0] wr_nib, rd_nib;
    logic [OVERFLOW_BITS-1:0]      wr_ovf, rd_ovf;

    // the read is issued in the read cycle, its data is used in the update cycle
    cmrc_bucket_store #(.ADDR_W(ADDR_W), .OVF_W(OVERFLOW_BITS)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_nib  (wr_nib),
        .wr_ovf  (wr_ovf),
        .rd_addr (addr_next),
        .rd_nib  (rd_nib),
        .rd_ovf  (rd_ovf)
    );

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cmrc_pkg::ST_CLEAR:  if (clr_reg == CLR_END - CLR_W'(1)) state_next = cmrc_pkg::ST_IDLE;
            cmrc_pkg::ST_IDLE:   if (s_fire) state_next = cmrc_pkg::ST_SEED;
            cmrc_pkg::ST_SEED:   state_next = cmrc_pkg::ST_H0;
            cmrc_pkg::ST_H0:     state_next = cmrc_pkg::ST_H1;
            cmrc_pkg::ST_H1:     state_next = cmrc_pkg::ST_H2;
            cmrc_pkg::ST_H2:     state_next = cmrc_pkg::ST_H3;
            cmrc_pkg::ST_H3:     state_next = cmrc_pkg::ST_H4;
            cmrc_pkg::ST_H4:     state_next = cmrc_pkg::ST_H5;
            cmrc_pkg::ST_H5:     state_next = COL_POW2 ? cmrc_pkg::ST_READ : cmrc_pkg::ST_MOD0;
            cmrc_pkg::ST_MOD0:   state_next = cmrc_pkg::ST_MOD1;
            cmrc_pkg::ST_MOD1:   state_next = cmrc_pkg::ST_READ;
            cmrc_pkg::ST_READ:   state_next = cmrc_pkg::ST_UPDATE;
            cmrc_pkg::ST_UPDATE: state_next = (row_reg == LAST_ROW) ? cmrc_pkg::ST_DONE
                                                                    : cmrc_pkg::ST_SEED;
            cmrc_pkg::ST_DONE:   if (!out_valid_reg || m_axis_tready) state_next = cmrc_pkg::ST_IDLE;
            default:             state_next = cmrc_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        hctl.mul_en  = 1'b0;
        hctl.mul_sel = cmrc_pkg::MS_SEED;
        case (state_reg)
            cmrc_pkg::ST_SEED: begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_SEED;  end
            cmrc_pkg::ST_H0:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_LO;    end
            cmrc_pkg::ST_H1:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_ROT;   end
            cmrc_pkg::ST_H2:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_HI;    end
            cmrc_pkg::ST_H3:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_ROT;   end
            cmrc_pkg::ST_H4:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_AV2;   end
            cmrc_pkg::ST_H5:   begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_AV3;   end
            cmrc_pkg::ST_MOD0: begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_RECIP; end
            cmrc_pkg::ST_MOD1: begin hctl.mul_en = 1'b1; hctl.mul_sel = cmrc_pkg::MS_QW;    end
            default:           begin hctl.mul_en = 1'b0; hctl.mul_sel = cmrc_pkg::MS_SEED;  end
        endcase
    end

    // a pending result does not block the input in the idle state, the output register parts the sides
    assign s_axis_tready = (state_reg == cmrc_pkg::ST_IDLE);

    // read-modify-write of the bucket for ref and deref (a query only reads), or zeroing during the clearing pass
    logic [SUM_W-1:0] sum;
    logic             row_under;
    assign sum = {1'b0, rd_ovf} + SUM_W'(rd_nib);

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = addr_reg;
        wr_nib    = rd_nib;
        wr_ovf    = rd_ovf;
        row_under = 1'b0;
        if (state_reg == cmrc_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[ADDR_W-1:0];
            wr_nib  = '0;
            wr_ovf  = '0;
        end else if (state_reg == cmrc_pkg::ST_UPDATE) begin
            if (op_reg == cmrc_pkg::OP_REF) begin
                wr_en = 1'b1;
                if (rd_nib >= cmrc_pkg::NIBBLE_MAX) begin
                    if (rd_ovf != OVF_MAX) wr_ovf = rd_ovf + OVERFLOW_BITS'(1);
                end else begin
                    wr_nib = rd_nib + cmrc_pkg::NIBBLE_W'(1);
                end
            end else if (op_reg == cmrc_pkg::OP_DEREF) begin
                wr_en = 1'b1;
                if (rd_ovf != '0) begin
                    wr_ovf = rd_ovf - OVERFLOW_BITS'(1);
                end else if (rd_nib != '0) begin
                    wr_nib = rd_nib - cmrc_pkg::NIBBLE_W'(1);
                end else begin
                    row_under = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmrc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == cmrc_pkg::ST_CLEAR) clr_reg <= clr_reg + CLR_W'(1);
            if (state_reg == cmrc_pkg::ST_DONE && state_next == cmrc_pkg::ST_IDLE) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and per-beat working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= s_axis_tdata[1:0];
            key_reg   <= s_axis_tdata[65:2];
            row_reg   <= '0;
            under_reg <= 1'b0;
            best_reg  <= '1;
        end
        if (state_reg == cmrc_pkg::ST_UPDATE) begin
            if (sum < best_reg) best_reg <= sum;
            under_reg <= under_reg | row_under;
            if (row_reg != LAST_ROW) row_reg <= row_reg + ROW_W'(1);
        end
        if (state_reg == cmrc_pkg::ST_DONE && state_next == cmrc_pkg::ST_IDLE) begin
            count_reg     <= (op_reg == cmrc_pkg::OP_QUERY)
                             ? cmrc_pkg::COUNT_W'(best_reg) : '0;
            out_under_reg <= (op_reg == cmrc_pkg::OP_DEREF) ? under_reg : 1'b0;
        end
    end

    // write address kept from the read cycle for the write-back
    logic addr_load;
    assign addr_load = (state_next == cmrc_pkg::ST_READ);

    logic addr_pending_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_pending_reg <= 1'b0;
        end else begin
            addr_pending_reg <= addr_load;
        end
        if (addr_pending_reg) addr_reg <= addr_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24-cmrc_pkg::COUNT_W){1'b0}}, count_reg};
    assign m_axis_tuser  = out_under_reg;

    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn,
                s_fire |=> (state_reg == cmrc_pkg::ST_SEED), "beat taken outside idle")
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
                (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
    `ASSERT_CLK(a_busy_not_ready, aclk, aresetn,
                (state_reg != cmrc_pkg::ST_IDLE) |-> !s_axis_tready, "ready while busy")
    `ASSERT_ALWAYS(a_reset_quiet, aclk,
                   !aresetn |=> (!m_axis_tvalid && !s_axis_tready),
                   "handshake active after reset")
endmodule
